[design/apt_pkg.sv]
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants for the access permission table.
// ----------------------------------------------------------------------------
package apt_pkg;

	localparam int ENTRIES   = 16;
	localparam int USER_BITS = 16;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W     = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		OP_GRANT_READ  = 2'd0,
		OP_GRANT_WRITE = 2'd1,
		OP_REMOVE      = 2'd2,
		OP_QUERY       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_OWNER     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_UPDATE
	} state_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_GRANT,
		CMD_INSERT,
		CMD_REMOVE
	} cmd_t;

	typedef struct packed {
		logic [USER_BITS-1:0] user;
		logic                 rd;
		logic                 wr;
	} entry_t;

	typedef struct packed {
		cmd_t                 cmd;
		logic                 set_write;
		logic                 cmp_en;
		logic [USER_BITS-1:0] uid;
		logic [IDX_W-1:0]     target;
		logic [CNT_W-1:0]     count;
	} cell_ctrl_t;

endpackage

[design/apt_cell.sv]
// ----------------------------------------------------------------------------
// apt_cell
// One table slot: holds an entry, compares it against the broadcast ID and
// takes its upper neighbor's entry when a removal closes the gap.
// ----------------------------------------------------------------------------
module apt_cell (
	input  logic                     clk,
	input  logic [apt_pkg::IDX_W-1:0] idx,
	input  apt_pkg::cell_ctrl_t      ctrl,
	input  apt_pkg::entry_t          nbr,
	output apt_pkg::entry_t          ent,
	output logic                     match
);

	apt_pkg::entry_t ent_q;
	logic            match_q;
	logic            slot_valid;

	assign slot_valid = apt_pkg::CNT_W'(idx) < ctrl.count;
	assign ent        = ent_q;
	assign match      = match_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			match_q <= slot_valid && (ent_q.user == ctrl.uid);
		end
		case (ctrl.cmd)
			apt_pkg::CMD_GRANT: begin
				if (idx == ctrl.target) begin
					ent_q.rd <= 1'b1;
					if (ctrl.set_write) begin
						ent_q.wr <= 1'b1;
					end
				end
			end
			apt_pkg::CMD_INSERT: begin
				if (idx == ctrl.target) begin
					ent_q.user <= ctrl.uid;
					ent_q.rd   <= 1'b1;
					ent_q.wr   <= ctrl.set_write;
				end
			end
			apt_pkg::CMD_REMOVE: begin
				if (idx >= ctrl.target) begin
					ent_q <= nbr;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[design/access_permission_table_core.sv]
// ----------------------------------------------------------------------------
// access_permission_table_core
// Permission table keyed by user ID, held in a row of compare cells.
//
//   channel | direction | words
//   in      | input     | op, user_id
//   out     | output    | status, can_read, can_write, is_owner, entry_count
//   cfg     | input     | cfg_data (owner ID)
//
// Each word passes a compare state, the parallel compare in the cells, then
// the update state: update and result register. The next word is taken there.
// A result waiting on out_ready holds the update and input stalls behind it.
// Reset empties the table at once; slot contents are undefined until written.
// ----------------------------------------------------------------------------
module access_permission_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [15:0] user_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        can_read,
	output logic        can_write,
	output logic        is_owner,
	output logic [4:0]  entry_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int E = apt_pkg::ENTRIES;

	apt_pkg::state_t                 state_q, state_d;
	apt_pkg::op_t                    op_q;
	logic [apt_pkg::USER_BITS-1:0]   uid_q;
	logic [apt_pkg::USER_BITS-1:0]   owner_q;
	logic [apt_pkg::CNT_W-1:0]       count_q, count_d;

	logic                            out_valid_q;
	apt_pkg::status_t                status_q, status_d;
	logic                            rd_q, rd_d, wr_q, wr_d, own_q;

	apt_pkg::cell_ctrl_t             ctrl;
	apt_pkg::entry_t                 ents [E];
	apt_pkg::entry_t                 nbrs [E];
	logic [E-1:0]                    match;

	logic                            apply, is_own, hit, full, set_w;
	logic [apt_pkg::IDX_W-1:0]       hit_idx;
	apt_pkg::entry_t                 hit_ent;

	genvar g;
	generate
		for (g = 0; g < E; g++) begin : g_cell
			if (g == E - 1) begin : g_last
				assign nbrs[g] = ents[g];
			end else begin : g_mid
				assign nbrs[g] = ents[g+1];
			end
			apt_cell u_cell (
				.clk   (clk),
				.idx   (apt_pkg::IDX_W'(g)),
				.ctrl  (ctrl),
				.nbr   (nbrs[g]),
				.ent   (ents[g]),
				.match (match[g])
			);
		end
	endgenerate

	always_comb begin
		hit_idx = '0;
		for (int i = E - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = apt_pkg::IDX_W'(i);
			end
		end
	end

	assign hit     = |match;
	assign hit_ent = ents[hit_idx];
	assign is_own  = (uid_q == owner_q);
	assign full    = (count_q == apt_pkg::CNT_W'(E));
	assign set_w   = (op_q == apt_pkg::OP_GRANT_WRITE);
	assign apply   = (state_q == apt_pkg::S_UPDATE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		count_d        = count_q;
		status_d       = apt_pkg::ST_OK;
		rd_d           = 1'b0;
		wr_d           = 1'b0;
		ctrl.cmd       = apt_pkg::CMD_NONE;
		ctrl.set_write = set_w;
		ctrl.cmp_en    = (state_q == apt_pkg::S_LOOKUP);
		ctrl.uid       = uid_q;
		ctrl.target    = hit_idx;
		ctrl.count     = count_q;

		if (is_own) begin
			rd_d = 1'b1;
			wr_d = 1'b1;
			if (op_q == apt_pkg::OP_REMOVE) begin
				status_d = apt_pkg::ST_OWNER;
			end
		end else begin
			case (op_q)
				apt_pkg::OP_GRANT_READ, apt_pkg::OP_GRANT_WRITE: begin
					if (hit) begin
						ctrl.cmd = apt_pkg::CMD_GRANT;
						rd_d     = 1'b1;
						wr_d     = hit_ent.wr | set_w;
					end else if (full) begin
						status_d = apt_pkg::ST_FULL;
					end else begin
						ctrl.cmd    = apt_pkg::CMD_INSERT;
						ctrl.target = apt_pkg::IDX_W'(count_q);
						count_d     = count_q + 1'b1;
						rd_d        = 1'b1;
						wr_d        = set_w;
					end
				end
				apt_pkg::OP_REMOVE: begin
					if (hit) begin
						ctrl.cmd = apt_pkg::CMD_REMOVE;
						count_d  = count_q - 1'b1;
					end else begin
						status_d = apt_pkg::ST_NOT_FOUND;
					end
				end
				default: begin
					if (hit) begin
						rd_d = hit_ent.rd;
						wr_d = hit_ent.wr;
					end else begin
						status_d = apt_pkg::ST_NOT_FOUND;
					end
				end
			endcase
		end

		case (state_q)
			apt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = apt_pkg::S_LOOKUP;
				end
			end
			apt_pkg::S_LOOKUP: begin
				state_d = apt_pkg::S_UPDATE;
			end
			apt_pkg::S_UPDATE: begin
				if (apply) begin
					in_ready = 1'b1;
					state_d  = in_valid ? apt_pkg::S_LOOKUP : apt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = apt_pkg::S_IDLE;
			end
		endcase

		if (!apply) begin
			ctrl.cmd = apt_pkg::CMD_NONE;
			count_d  = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= apt_pkg::S_IDLE;
			count_q     <= '0;
			owner_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_valid) begin
				owner_q <= apt_pkg::USER_BITS'(cfg_data);
			end
			if (apply) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= apt_pkg::op_t'(op);
			uid_q <= apt_pkg::USER_BITS'(user_id);
		end
		if (apply) begin
			status_q <= status_d;
			rd_q     <= rd_d;
			wr_q     <= wr_d;
			own_q    <= is_own;
		end
	end

	logic [4:0] count_out_q;
	always_ff @(posedge clk) begin
		if (apply) begin
			count_out_q <= 5'(count_d);
		end
	end

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign can_read    = rd_q;
	assign can_write   = wr_q;
	assign is_owner    = own_q;
	assign entry_count = count_out_q;

	a_lookup_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == apt_pkg::S_LOOKUP |=> state_q == apt_pkg::S_UPDATE)
		else $error("compare cycle not followed by update");

	a_accept_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == apt_pkg::S_LOOKUP)
		else $error("accepted word did not enter compare");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= apt_pkg::CNT_W'(E))
		else $error("entry count above table size");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cmd == apt_pkg::CMD_INSERT |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not bump entry count");

endmodule

[tb/sv/apt_tb_pkg.sv]
// ----------------------------------------------------------------------------
// apt_tb_pkg
// Tracks the permission table from accepted request words and checks every
// reply word against the tracked state, in order.
// ----------------------------------------------------------------------------
package apt_tb_pkg;

	import apt_pkg::*;

	typedef struct {
		status_t    status;
		bit         rd;
		bit         wr;
		bit         own;
		bit [4:0]   cnt;
	} perm_reply_t;

	class perm_table_checker;
		bit [USER_BITS-1:0] owner;
		bit [USER_BITS-1:0] slot_user[ENTRIES];
		bit                 slot_rd[ENTRIES];
		bit                 slot_wr[ENTRIES];
		int unsigned        used;
		perm_reply_t        pending_replies[$];
		int                 mismatches;
		int                 n_checked;
		int                 status_seen[4];

		// update the tracked table and queue the reply it implies
		function void apply_request(op_t req, bit [USER_BITS-1:0] uid);
			perm_reply_t r;
			int          idx;
			r.status = ST_OK;
			r.rd     = 0;
			r.wr     = 0;
			r.own    = 0;
			idx      = -1;
			if (uid == owner) begin
				r.own    = 1;
				r.rd     = 1;
				r.wr     = 1;
				r.status = (req == OP_REMOVE) ? ST_OWNER : ST_OK;
			end else begin
				for (int i = 0; i < used; i++)
					if (idx < 0 && slot_user[i] == uid) idx = i;
				case (req)
					OP_GRANT_READ, OP_GRANT_WRITE: begin
						if (idx >= 0) begin
							slot_rd[idx] = 1;
							if (req == OP_GRANT_WRITE) slot_wr[idx] = 1;
							r.rd = 1;
							r.wr = slot_wr[idx];
						end else if (used >= ENTRIES) begin
							r.status = ST_FULL;
						end else begin
							slot_user[used] = uid;
							slot_rd[used]   = 1;
							slot_wr[used]   = (req == OP_GRANT_WRITE);
							r.rd = 1;
							r.wr = slot_wr[used];
							used++;
						end
					end
					OP_REMOVE: begin
						if (idx >= 0) begin
							for (int j = idx; j + 1 < used; j++) begin
								slot_user[j] = slot_user[j+1];
								slot_rd[j]   = slot_rd[j+1];
								slot_wr[j]   = slot_wr[j+1];
							end
							used--;
						end else begin
							r.status = ST_NOT_FOUND;
						end
					end
					default: begin
						if (idx >= 0) begin
							r.rd = slot_rd[idx];
							r.wr = slot_wr[idx];
						end else begin
							r.status = ST_NOT_FOUND;
						end
					end
				endcase
			end
			r.cnt = 5'(used);
			status_seen[r.status]++;
			pending_replies.push_back(r);
		endfunction

		task flag_mismatch(string msg);
			mismatches++;
			$display("MISMATCH %s", msg);
		endtask

		task check_reply(logic [1:0] st, logic rd, logic wr, logic own, logic [4:0] cnt);
			perm_reply_t e;
			if (pending_replies.size() == 0) begin
				flag_mismatch("reply word with no request outstanding");
				return;
			end
			e = pending_replies.pop_front();
			n_checked++;
			if (st !== e.status)
				flag_mismatch($sformatf("reply %0d: status %0d, expected %0d",
					n_checked, st, e.status));
			if (rd !== e.rd)
				flag_mismatch($sformatf("reply %0d: can_read %0b, expected %0b",
					n_checked, rd, e.rd));
			if (wr !== e.wr)
				flag_mismatch($sformatf("reply %0d: can_write %0b, expected %0b",
					n_checked, wr, e.wr));
			if (own !== e.own)
				flag_mismatch($sformatf("reply %0d: is_owner %0b, expected %0b",
					n_checked, own, e.own));
			if (cnt !== e.cnt)
				flag_mismatch($sformatf("reply %0d: entry_count %0d, expected %0d",
					n_checked, cnt, e.cnt));
		endtask
	endclass

endpackage

[tb/sv/tb_access_permission_table_core.sv]
// ----------------------------------------------------------------------------
// tb_access_permission_table_core
// Drives grant, remove and query words into the permission table under
// several owner settings, with random idling on both sides and one long
// output stall, and checks each reply word against the tracked table.
// ----------------------------------------------------------------------------
module tb_access_permission_table_core;

	timeunit 1ns;
	timeprecision 1ps;

	import apt_pkg::*;
	import apt_tb_pkg::*;

	localparam int POOL_N         = 22;
	localparam int PHASE_WORDS    = 310;
	localparam int WATCHDOG_LIMIT = 4000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [15:0] user_id;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic        can_read;
	logic        can_write;
	logic        is_owner;
	logic [4:0]  entry_count;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	perm_table_checker sb;
	bit [15:0]         pool[POOL_N];
	bit                idle_en;
	bit                hold_req;
	int                n_cfg;

	access_permission_table_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.user_id     (user_id),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.can_read    (can_read),
		.can_write   (can_write),
		.is_owner    (is_owner),
		.entry_count (entry_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_word(op_t req, bit [15:0] uid);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= req;
		user_id  <= uid;
		do @(posedge clk); while (!in_ready);
		sb.apply_request(req, uid);
	endtask

	task automatic write_owner(bit [15:0] value);
		in_valid <= 1'b0;
		while (sb.pending_replies.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.owner = value;
		n_cfg++;
		cfg_valid <= 1'b0;
	endtask

	// output side: random stalls, plus one long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_reply(status, can_read, can_write, is_owner, entry_count);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = 240;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 17);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
			    (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("FAIL access_permission_table_core");
		$finish;
	end

	initial begin
		bit [15:0] next_owner;
		bit [15:0] uid;
		op_t       req;
		int        mood;
		int        r;
		in_valid  <= 1'b0;
		op        <= OP_QUERY;
		user_id   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		sb        = new;
		idle_en   = 1'b1;
		hold_req  = 1'b0;
		n_cfg     = 0;
		mood      = 0;
		pool[0]   = 16'h0000;
		pool[1]   = 16'hFFFF;
		for (int i = 2; i < POOL_N; i++) pool[i] = 16'($urandom);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// owner is 0 out of reset
		send_word(OP_QUERY, 16'h0000);
		send_word(OP_REMOVE, 16'h0000);
		send_word(OP_GRANT_WRITE, 16'h0000);
		send_word(OP_QUERY, 16'hFFFF);
		send_word(OP_REMOVE, 16'hFFFF);
		send_word(OP_GRANT_READ, 16'hFFFF);
		send_word(OP_GRANT_WRITE, 16'hFFFF);
		send_word(OP_GRANT_READ, 16'hFFFF);
		for (int k = 2; k <= 16; k++)
			send_word((k % 2) ? OP_GRANT_WRITE : OP_GRANT_READ, pool[k]);
		send_word(OP_GRANT_READ, pool[17]);
		send_word(OP_GRANT_WRITE, pool[2]);
		send_word(OP_REMOVE, pool[8]);
		send_word(OP_QUERY, pool[9]);
		send_word(OP_QUERY, pool[8]);
		// owner that also sits in a table slot
		write_owner(pool[5]);
		send_word(OP_QUERY, pool[5]);
		send_word(OP_REMOVE, pool[5]);
		send_word(OP_GRANT_WRITE, pool[5]);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: next_owner = 16'hFFFF;
				1: next_owner = 16'h0000;
				2: next_owner = pool[5];
				4: next_owner = pool[9];
				default: next_owner = 16'($urandom);
			endcase
			if (ph == 5) idle_en = 1'b0;
			write_owner(next_owner);
			if (ph == 2) hold_req = 1'b1;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (k % 40 == 0) begin
					mood = $urandom_range(0, 2);
					if (ph != 5) idle_en = ($urandom_range(0, 2) != 0);
				end
				r = $urandom_range(0, 99);
				case (mood)
					0: req = (r < 35) ? OP_GRANT_READ : (r < 70) ? OP_GRANT_WRITE :
						(r < 85) ? OP_REMOVE : OP_QUERY;
					1: req = (r < 15) ? OP_GRANT_READ : (r < 30) ? OP_GRANT_WRITE :
						(r < 70) ? OP_REMOVE : OP_QUERY;
					default: req = op_t'(r % 4);
				endcase
				r = $urandom_range(0, 99);
				if (r < 80)      uid = pool[$urandom_range(0, POOL_N - 1)];
				else if (r < 88) uid = sb.owner;
				else             uid = 16'($urandom);
				send_word(req, uid);
			end
		end
		in_valid <= 1'b0;

		while (sb.pending_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Checked %0d replies across %0d owner settings, with one long output hold",
			sb.n_checked, n_cfg);
		$display("Replies by status: %0d ok, %0d full, %0d owner refused, %0d not found",
			sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_OWNER],
			sb.status_seen[ST_NOT_FOUND]);
		if (sb.mismatches == 0)
			$display("PASS access_permission_table_core");
		else
			$display("FAIL access_permission_table_core");
		$finish;
	end

endmodule
